FILE: src/zbtf_pkg.sv
// zbtf_pkg: operation codes, field widths and the texture port request type
// shared by the fragment stage top level and its texture memory
// no dependencies
`default_nettype none

package zbtf_pkg;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
  localparam logic [OP_W-1:0] OP_TEXEL    = 2'd1;
  localparam logic [OP_W-1:0] OP_FLAT     = 2'd2;
  localparam logic [OP_W-1:0] OP_TEXTURED = 2'd3;

  localparam int COORD_W  = 11;
  localparam int TEX_BITS = 11;
  localparam int TEX_DIM  = 2048;
  localparam int TEX_AW   = 2 * TEX_BITS;
  localparam int DEPTH_W  = 16;
  localparam int COLOR_W  = 16;

  localparam logic [DEPTH_W-1:0] DEPTH_FAR = 16'hffff;

  // texture port request: texel write from a write op, texel fetch for a textured fragment
  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [COORD_W-1:0] wr_col;
    logic [COORD_W-1:0] wr_row;
    logic [7:0]         wr_data;
    logic [31:0]        u;
    logic [31:0]        v;
    logic [15:0]        base;
    logic               wrap_u;
    logic               wrap_v;
  } tex_req_t;

endpackage

`default_nettype wire

FILE: src/zbtf_texture_mem.sv
// zbtf_texture_mem: 2048 x 2048 byte texture memory with texel coordinate
// generation (64-texel wrap inside a base window) and a registered read port
// depends on zbtf_pkg
`default_nettype none

module zbtf_texture_mem (
  input  wire logic              clk,
  input  wire zbtf_pkg::tex_req_t req,
  output logic [7:0]              texel
);

  logic [7:0] tex_mem [zbtf_pkg::TEX_DIM * zbtf_pkg::TEX_DIM];

  logic [11:0]                       base_u;
  logic [11:0]                       base_v;
  logic [11:0]                       wrap_col;
  logic [11:0]                       wrap_row;
  logic [zbtf_pkg::TEX_BITS-1:0]     rd_col;
  logic [zbtf_pkg::TEX_BITS-1:0]     rd_row;
  logic [zbtf_pkg::TEX_AW-1:0]       rd_addr;
  logic [zbtf_pkg::TEX_AW-1:0]       wr_addr;

  always_comb begin
    base_u   = {req.base[7:0], 4'b0000};
    base_v   = {req.base[15:8], 4'b0000};
    // window base plus the low six bits of the texel index
    wrap_col = base_u + {6'd0, req.u[25:20]};
    wrap_row = base_v + {6'd0, req.v[25:20]};
    rd_col   = req.wrap_u ? wrap_col[zbtf_pkg::TEX_BITS-1:0] : req.u[30:20];
    rd_row   = req.wrap_v ? wrap_row[zbtf_pkg::TEX_BITS-1:0] : req.v[30:20];
    rd_addr  = {rd_row, rd_col};
    wr_addr  = {req.wr_row, req.wr_col};
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      tex_mem[wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      texel <= tex_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/zbuffered_texture_fragment_stage.sv
// zbuffered_texture_fragment_stage: per-fragment back end with a depth store,
// depth test with forwarding and textured / shaded color generation
// depends on zbtf_pkg and zbtf_texture_mem
//
// usage:
//   s_axis carries one operation per word: clear pixel, write texel, flat or
//   shaded fragment, textured fragment (kind in tuser). m_axis returns exactly
//   one word per input word, in order: pixel_write in tuser, frame position
//   and color in tdata. a word with pixel_write low carries zero fields.
//   throughput: one word per cycle, sustained, with mixed operations, while
//   m_axis does not stall. a word is registered in the test stage on accept
//   (depth and texel memory read) and in the output register after the test
//   and write back. the depth store is written back when the word leaves the
//   test stage; the last write back is forwarded so that neighboring fragments
//   on the same pixel see each other at full rate.
//   reset clears the pipeline, forwarding and output valid flags only; depth
//   and texture contents are undefined until written, there is no clearing
//   pass. when m_axis stalls the output register and the test stage hold
//   and s_axis_tready drops only once both are full.
`default_nettype none

module zbuffered_texture_fragment_stage #(
  parameter int SCREEN_WIDTH  = 512,
  parameter int SCREEN_HEIGHT = 512
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pixel_x, pixel_y, depth_fixed, color_fixed, u_fixed, v_fixed,
  // texture_base, wrap_u, wrap_v, texel_value
  input  wire logic [175:0] s_axis_tdata,
  // operation
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_x, out_y, pixel_color, two zero bits
  output logic [39:0]       m_axis_tdata,
  // pixel_write
  output logic [0:0]        m_axis_tuser
);

  localparam int DEPTH_ENTRIES = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int DEPTH_AW      = $clog2(DEPTH_ENTRIES);
  localparam int PROD_W        = 2 * zbtf_pkg::COORD_W;
  localparam logic [zbtf_pkg::COORD_W:0] SW_L = (zbtf_pkg::COORD_W + 1)'(SCREEN_WIDTH);
  localparam logic [zbtf_pkg::COORD_W:0] SH_L = (zbtf_pkg::COORD_W + 1)'(SCREEN_HEIGHT);

  // input fields
  logic [zbtf_pkg::OP_W-1:0]    in_op;
  logic [zbtf_pkg::COORD_W-1:0] in_x;
  logic [zbtf_pkg::COORD_W-1:0] in_y;
  logic [31:0]                  in_depth;
  logic [31:0]                  in_color;
  logic [31:0]                  in_u;
  logic [31:0]                  in_v;
  logic [15:0]                  in_base;
  logic                         in_wrap_u;
  logic                         in_wrap_v;
  logic [7:0]                   in_texel;

  assign in_op     = s_axis_tuser;
  assign in_x      = s_axis_tdata[10:0];
  assign in_y      = s_axis_tdata[21:11];
  assign in_depth  = s_axis_tdata[53:22];
  assign in_color  = s_axis_tdata[85:54];
  assign in_u      = s_axis_tdata[117:86];
  assign in_v      = s_axis_tdata[149:118];
  assign in_base   = s_axis_tdata[165:150];
  assign in_wrap_u = s_axis_tdata[166];
  assign in_wrap_v = s_axis_tdata[167];
  assign in_texel  = s_axis_tdata[175:168];

  logic                  in_accept;
  logic                  in_on_screen;
  logic [PROD_W-1:0]     row_start;
  logic [PROD_W-1:0]     addr_sum;
  logic [DEPTH_AW-1:0]   in_addr;

  // test stage
  logic                          s1_valid;
  logic [zbtf_pkg::OP_W-1:0]     s1_op;
  logic                          s1_on_screen;
  logic [zbtf_pkg::COORD_W-1:0]  s1_x;
  logic [zbtf_pkg::COORD_W-1:0]  s1_y;
  logic [zbtf_pkg::DEPTH_W-1:0]  s1_iz;
  logic [zbtf_pkg::COLOR_W-1:0]  s1_color;
  logic [DEPTH_AW-1:0]           s1_addr;
  logic                          s1_advance;

  // last depth write back
  logic                          fwd_valid;
  logic [DEPTH_AW-1:0]           fwd_addr;
  logic [zbtf_pkg::DEPTH_W-1:0]  fwd_data;

  logic [zbtf_pkg::DEPTH_W-1:0]  depth_mem [DEPTH_ENTRIES];
  logic [zbtf_pkg::DEPTH_W-1:0]  depth_q;
  logic [zbtf_pkg::DEPTH_W-1:0]  stored_z;
  logic [7:0]                    texel;
  logic                          z_pass;
  logic                          s1_write;
  logic [zbtf_pkg::COLOR_W-1:0]  s1_pix;
  logic                          dwr_en;
  logic [zbtf_pkg::DEPTH_W-1:0]  dwr_data;

  // output register
  logic                          out_valid;
  logic                          out_write;
  logic [zbtf_pkg::COORD_W-1:0]  out_x;
  logic [zbtf_pkg::COORD_W-1:0]  out_y;
  logic [zbtf_pkg::COLOR_W-1:0]  out_color;

  zbtf_pkg::tex_req_t tex_req;

  assign s1_advance    = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_on_screen = ({1'b0, in_x} < SW_L) && ({1'b0, in_y} < SH_L);
    row_start    = PROD_W'(in_y) * PROD_W'(SCREEN_WIDTH);
    addr_sum     = row_start + PROD_W'(in_x);
    in_addr      = addr_sum[DEPTH_AW-1:0];
  end

  always_comb begin
    tex_req.rd_en   = in_accept && (in_op == zbtf_pkg::OP_TEXTURED);
    tex_req.wr_en   = in_accept && (in_op == zbtf_pkg::OP_TEXEL);
    tex_req.wr_col  = in_x;
    tex_req.wr_row  = in_y;
    tex_req.wr_data = in_texel;
    tex_req.u       = in_u;
    tex_req.v       = in_v;
    tex_req.base    = in_base;
    tex_req.wrap_u  = in_wrap_u;
    tex_req.wrap_v  = in_wrap_v;
  end

  zbtf_texture_mem u_texture (
    .clk   (clk),
    .req   (tex_req),
    .texel (texel)
  );

  // depth store: read on accept of an on-screen word, write back from the test stage
  always_ff @(posedge clk) begin
    if (in_accept && in_on_screen) begin
      depth_q <= depth_mem[in_addr];
    end
    if (dwr_en) begin
      depth_mem[s1_addr] <= dwr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op        <= in_op;
      s1_on_screen <= in_on_screen;
      s1_x         <= in_x;
      s1_y         <= in_y;
      s1_iz        <= in_depth[31:16];
      s1_color     <= in_color[31:16];
      s1_addr      <= in_addr;
    end
  end

  always_comb begin
    // the latest write back may not have reached the registered read yet
    stored_z = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : depth_q;
    z_pass   = s1_iz <= stored_z;
    s1_write = 1'b0;
    s1_pix   = '0;
    dwr_data = s1_iz;
    case (s1_op)
      zbtf_pkg::OP_CLEAR: begin
        s1_write = s1_on_screen;
        dwr_data = zbtf_pkg::DEPTH_FAR;
      end
      zbtf_pkg::OP_FLAT: begin
        s1_write = s1_on_screen && z_pass;
        s1_pix   = s1_color;
      end
      zbtf_pkg::OP_TEXTURED: begin
        s1_write = s1_on_screen && z_pass && (texel != 8'd0);
        s1_pix   = {1'b0, s1_color[6:0], texel};
      end
      default: begin
        s1_write = 1'b0;
      end
    endcase
    dwr_en = s1_advance && s1_write;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (dwr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dwr_en) begin
      fwd_addr <= s1_addr;
      fwd_data <= dwr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_write <= s1_write;
      out_x     <= s1_write ? s1_x : '0;
      out_y     <= s1_write ? s1_y : '0;
      out_color <= s1_write ? s1_pix : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_write;
  assign m_axis_tdata  = {2'b00, out_color, out_y, out_x};

  // an accepted word always lands in the test stage
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("accepted word did not enter test stage");

  // a stalled test stage keeps its word
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_op) && $stable(s1_addr)))
    else $error("test stage changed while stalled");

  // forwarding register tracks the last write back
  a_fwd_tracks: assert property (@(posedge clk) disable iff (rst)
    dwr_en |=> (fwd_valid && fwd_addr == $past(s1_addr) && fwd_data == $past(dwr_data)))
    else $error("forward register missed a depth write");

  // a pixel write is always on screen
  a_write_on_screen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_write) |-> (({1'b0, out_x} < SW_L) && ({1'b0, out_y} < SH_L)))
    else $error("pixel write outside the screen");

endmodule

`default_nettype wire
